// ----- rtl/hptu_pkg.sv -----
// Shared types and constants for the homogeneous point transform unit.
package hptu_pkg;

   localparam int PAIR_COUNT   = 8;
   localparam int PAIR_INDEX_W = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int COEF_W       = 32;

   typedef struct packed {
      logic valid;
      logic fault;
   } pipe_ctl_type;

   typedef struct packed {
      logic div_mode;
      logic neg;
      logic ovf;
      logic sat;
   } lane_ctl_type;

endpackage

// ----- rtl/hptu_mac.sv -----
// Matrix multiply stages: registered products, then registered row sums.
module hptu_mac #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   parameter int ACC_WIDTH   = 66
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic signed [COORD_WIDTH-1:0]         pt [3],
   input  logic signed [hptu_pkg::COEF_W-1:0]    coef [4][4],
   output logic                                  out_valid,
   output logic signed [ACC_WIDTH-1:0]           acc [4]
);
   import hptu_pkg::*;

   localparam int PW = COORD_WIDTH + COEF_W;

   logic signed [PW-1:0]        prod_ff [4][3];
   logic signed [ACC_WIDTH-1:0] bias_ff [4];
   logic signed [ACC_WIDTH-1:0] acc_ff [4];
   logic signed [ACC_WIDTH-1:0] acc_in [4];
   logic                        v1_ff;
   logic                        v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= PW'(pt[c]) * PW'(coef[r][c]);
            end
            // translation column scaled up to the product's fraction
            bias_ff[r] <= ACC_WIDTH'(coef[r][3]) <<< FRAC_BITS;
         end
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         acc_in[r] = bias_ff[r] + ACC_WIDTH'(prod_ff[r][0]) + ACC_WIDTH'(prod_ff[r][1])
                   + ACC_WIDTH'(prod_ff[r][2]);
      end
   end

   assign out_valid = v2_ff;
   assign acc       = acc_ff;

endmodule

// ----- rtl/hptu_prep.sv -----
// Magnitudes, w tests, non-divide results and divider operand setup.
module hptu_prep #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   parameter int ACC_WIDTH   = 66
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [ACC_WIDTH-1:0]    acc [4],
   output hptu_pkg::pipe_ctl_type         ctl,
   output hptu_pkg::lane_ctl_type         lane [3],
   output logic [COORD_WIDTH-1:0]         fix [3],
   output logic [ACC_WIDTH:0]             d2,
   output logic [ACC_WIDTH:0]             rem [3],
   output logic [COORD_WIDTH-1:0]         nlow [3]
);
   import hptu_pkg::*;

   localparam int NW   = ACC_WIDTH + FRAC_BITS + 1;
   localparam int SHW  = ACC_WIDTH + 1 + COORD_WIDTH;
   localparam int CMPW = (NW > SHW) ? NW : SHW;
   localparam logic [ACC_WIDTH-1:0]   UNIT     = ACC_WIDTH'(1) << (2 * FRAC_BITS);
   localparam logic [ACC_WIDTH:0]     HALF_LSB = (ACC_WIDTH + 1)'(1) << (FRAC_BITS - 1);
   localparam logic [ACC_WIDTH:0]     LIM_NEG  = (ACC_WIDTH + 1)'(1) << (COORD_WIDTH - 1);
   localparam logic [ACC_WIDTH:0]     LIM_POS  = LIM_NEG - (ACC_WIDTH + 1)'(1);
   localparam logic [COORD_WIDTH-1:0] VAL_MAX  = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] VAL_MIN  = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

   // first stage: sign/magnitude split and w tests
   logic                 v3_ff;
   logic                 neg_ff [4];
   logic [ACC_WIDTH-1:0] mag_ff [4];
   logic                 one_ff;
   logic                 zero_ff;

   // second stage
   pipe_ctl_type            ctl_ff;
   lane_ctl_type            lane_ff [3];
   lane_ctl_type            lane_in [3];
   logic [COORD_WIDTH-1:0]  fix_ff [3];
   logic [COORD_WIDTH-1:0]  fix_in [3];
   logic [ACC_WIDTH:0]      d2_ff;
   logic [ACC_WIDTH:0]      d2_in;
   logic [ACC_WIDTH:0]      rem_ff [3];
   logic [ACC_WIDTH:0]      rem_in [3];
   logic [COORD_WIDTH-1:0]  nlow_ff [3];
   logic [COORD_WIDTH-1:0]  nlow_in [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff  <= 1'b0;
         ctl_ff <= '0;
      end else if (en) begin
         v3_ff        <= in_valid;
         ctl_ff.valid <= v3_ff;
         ctl_ff.fault <= zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            neg_ff[r] <= acc[r][ACC_WIDTH-1];
            mag_ff[r] <= acc[r][ACC_WIDTH-1] ? ACC_WIDTH'(-acc[r]) : ACC_WIDTH'(acc[r]);
         end
         one_ff  <= ($unsigned(acc[3]) == UNIT);
         zero_ff <= (acc[3] == '0);
         lane_ff <= lane_in;
         fix_ff  <= fix_in;
         d2_ff   <= d2_in;
         rem_ff  <= rem_in;
         nlow_ff <= nlow_in;
      end
   end

   always_comb begin
      logic [NW-1:0]        n;
      logic [ACC_WIDTH:0]   rnd;
      logic [ACC_WIDTH:0]   lim;
      logic [ACC_WIDTH:0]   m;
      d2_in = {mag_ff[3], 1'b0};
      for (int c = 0; c < 3; c++) begin
         // numerator carries the half-divisor so the quotient rounds to nearest
         n = (NW'(mag_ff[c]) << (FRAC_BITS + 1)) + NW'(mag_ff[3]);
         rem_in[c]           = (ACC_WIDTH + 1)'(n >> COORD_WIDTH);
         nlow_in[c]          = n[COORD_WIDTH-1:0];
         lane_in[c].div_mode = !one_ff && !zero_ff;
         lane_in[c].neg      = neg_ff[c] ^ neg_ff[3];
         lane_in[c].ovf      = CMPW'(n) >= (CMPW'(d2_in) << COORD_WIDTH);

         rnd = ((ACC_WIDTH + 1)'(mag_ff[c]) + HALF_LSB) >> FRAC_BITS;
         lim = neg_ff[c] ? LIM_NEG : LIM_POS;
         m   = (rnd > lim) ? lim : rnd;
         if (one_ff) begin
            lane_in[c].sat = (rnd > lim);
            fix_in[c]      = neg_ff[c] ? -COORD_WIDTH'(m) : COORD_WIDTH'(m);
         end else if (mag_ff[c] == '0) begin
            lane_in[c].sat = 1'b0;
            fix_in[c]      = '0;
         end else begin
            // zero w: clip toward the sign of the sum
            lane_in[c].sat = 1'b1;
            fix_in[c]      = neg_ff[c] ? VAL_MIN : VAL_MAX;
         end
      end
   end

   assign ctl  = ctl_ff;
   assign lane = lane_ff;
   assign fix  = fix_ff;
   assign d2   = d2_ff;
   assign rem  = rem_ff;
   assign nlow = nlow_ff;

endmodule

// ----- rtl/hptu_div.sv -----
// Pipelined restoring divider for one coordinate, one quotient bit per stage.
module hptu_div #(
   parameter int COORD_WIDTH = 32,
   parameter int ACC_WIDTH   = 66
) (
   input  logic                     clock,
   input  logic                     en,
   input  hptu_pkg::lane_ctl_type   ctl_in,
   input  logic [COORD_WIDTH-1:0]   fix_in,
   input  logic [ACC_WIDTH:0]       d2_in,
   input  logic [ACC_WIDTH:0]       rem_start,
   input  logic [COORD_WIDTH-1:0]   nlow_in,
   output hptu_pkg::lane_ctl_type   ctl_out,
   output logic [COORD_WIDTH-1:0]   fix_out,
   output logic [COORD_WIDTH-1:0]   q_out
);
   import hptu_pkg::*;

   logic [ACC_WIDTH:0]     rem_ff [COORD_WIDTH];
   logic [ACC_WIDTH:0]     d_ff   [COORD_WIDTH];
   logic [COORD_WIDTH-1:0] low_ff [COORD_WIDTH];
   logic [COORD_WIDTH-1:0] q_ff   [COORD_WIDTH];
   logic [COORD_WIDTH-1:0] fix_ff [COORD_WIDTH];
   lane_ctl_type           ctl_ff [COORD_WIDTH];

   for (genvar i = 0; i < COORD_WIDTH; i++) begin : g_stage
      logic [ACC_WIDTH:0]     rem_cur;
      logic [ACC_WIDTH:0]     d_cur;
      logic [COORD_WIDTH-1:0] low_cur;
      logic [COORD_WIDTH-1:0] q_cur;
      logic [COORD_WIDTH-1:0] fix_cur;
      lane_ctl_type           ctl_cur;
      logic [ACC_WIDTH+1:0]   trial;
      logic                   ge;
      logic [ACC_WIDTH:0]     rem_in;

      if (i == 0) begin : g_first
         assign rem_cur = rem_start;
         assign d_cur   = d2_in;
         assign low_cur = nlow_in;
         assign q_cur   = '0;
         assign fix_cur = fix_in;
         assign ctl_cur = ctl_in;
      end else begin : g_next
         assign rem_cur = rem_ff[i-1];
         assign d_cur   = d_ff[i-1];
         assign low_cur = low_ff[i-1];
         assign q_cur   = q_ff[i-1];
         assign fix_cur = fix_ff[i-1];
         assign ctl_cur = ctl_ff[i-1];
      end

      assign trial  = {rem_cur, low_cur[COORD_WIDTH-1]};
      assign ge     = trial >= {1'b0, d_cur};
      assign rem_in = ge ? (ACC_WIDTH + 1)'(trial - {1'b0, d_cur}) : (ACC_WIDTH + 1)'(trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            d_ff[i]   <= d_cur;
            low_ff[i] <= low_cur << 1;
            q_ff[i]   <= {q_cur[COORD_WIDTH-2:0], ge};
            fix_ff[i] <= fix_cur;
            ctl_ff[i] <= ctl_cur;
         end
      end
   end

   assign ctl_out = ctl_ff[COORD_WIDTH-1];
   assign fix_out = fix_ff[COORD_WIDTH-1];
   assign q_out   = q_ff[COORD_WIDTH-1];

endmodule

// ----- rtl/hptu_out.sv -----
// Final sign, clipping and flag merge into the result register.
module hptu_out #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  hptu_pkg::pipe_ctl_type   ctl,
   input  hptu_pkg::lane_ctl_type   lane [3],
   input  logic [COORD_WIDTH-1:0]   fix [3],
   input  logic [COORD_WIDTH-1:0]   q [3],
   output logic                     out_valid,
   output logic [COORD_WIDTH-1:0]   val [3],
   output logic                     saturated,
   output logic                     fault
);
   import hptu_pkg::*;

   localparam logic [COORD_WIDTH-1:0] LIM_NEG = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
   localparam logic [COORD_WIDTH-1:0] LIM_POS = {1'b0, {(COORD_WIDTH - 1){1'b1}}};

   logic                   valid_ff;
   logic [COORD_WIDTH-1:0] val_ff [3];
   logic [COORD_WIDTH-1:0] val_in [3];
   logic                   sat_ff;
   logic                   sat_in;
   logic                   fault_ff;

   always_comb begin
      logic                   qneg;
      logic                   over;
      logic [COORD_WIDTH-1:0] lim;
      logic [COORD_WIDTH-1:0] m;
      sat_in = 1'b0;
      for (int c = 0; c < 3; c++) begin
         // a zero quotient is never negative
         qneg = lane[c].neg && (lane[c].ovf || (q[c] != '0));
         lim  = qneg ? LIM_NEG : LIM_POS;
         over = lane[c].ovf || (q[c] > lim);
         m    = over ? lim : q[c];
         if (lane[c].div_mode) begin
            val_in[c] = qneg ? -m : m;
            sat_in    = sat_in | over;
         end else begin
            val_in[c] = fix[c];
            sat_in    = sat_in | lane[c].sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff   <= val_in;
         sat_ff   <= sat_in;
         fault_ff <= ctl.fault;
      end
   end

   assign out_valid = valid_ff;
   assign val       = val_ff;
   assign saturated = sat_ff;
   assign fault     = fault_ff;

endmodule

// ----- rtl/homogeneous_point_transform_unit.sv -----
// Transforms a Q point (x,y,z,1) by a 4x4 Q-format matrix from eight 64-bit coefficient
// registers (reset: identity), divides by w unless w is exactly 1.0 or zero, rounds to
// nearest and saturates. One point enters per clock unless the result stalls; the
// pipeline length is set by the restoring divider (one quotient bit per stage for each
// coordinate). A stalled result holds the whole pipeline; nothing is dropped or repeated.
module homogeneous_point_transform_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [hptu_pkg::PAIR_INDEX_W-1:0]    csr_index,
   input  logic [hptu_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [COORD_WIDTH-1:0]        req_in_x,
   input  logic signed [COORD_WIDTH-1:0]        req_in_y,
   input  logic signed [COORD_WIDTH-1:0]        req_in_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [COORD_WIDTH-1:0]        rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]        rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]        rsp_out_z,
   output logic                                 rsp_saturated,
   output logic                                 rsp_zero_w_fault
);
   import hptu_pkg::*;

   localparam int PROD_W    = COORD_WIDTH + COEF_W;
   localparam int BIAS_W    = COEF_W + FRAC_BITS;
   localparam int ACC_WIDTH = ((PROD_W > BIAS_W) ? PROD_W : BIAS_W) + 2;
   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;

   logic                    en;
   logic [CSR_DATA_W-1:0]   pair_ff [PAIR_COUNT];
   logic [CSR_DATA_W-1:0]   pair_rst [PAIR_COUNT];
   logic signed [COEF_W-1:0] coef [4][4];
   logic signed [COORD_WIDTH-1:0] pt [3];

   logic                        mac_valid;
   logic signed [ACC_WIDTH-1:0] acc [4];

   pipe_ctl_type            prep_ctl;
   lane_ctl_type            prep_lane [3];
   logic [COORD_WIDTH-1:0]  prep_fix [3];
   logic [ACC_WIDTH:0]      prep_d2;
   logic [ACC_WIDTH:0]      prep_rem [3];
   logic [COORD_WIDTH-1:0]  prep_nlow [3];

   pipe_ctl_type            ctl_dl_ff [COORD_WIDTH];
   lane_ctl_type            div_lane [3];
   logic [COORD_WIDTH-1:0]  div_fix [3];
   logic [COORD_WIDTH-1:0]  div_q [3];
   logic [COORD_WIDTH-1:0]  res [3];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_comb begin
      for (int k = 0; k < PAIR_COUNT; k++) begin
         pair_rst[k] = '0;
      end
      for (int r = 0; r < 4; r++) begin
         pair_rst[2 * r + r / 2][COEF_W * (r % 2) +: COEF_W] = COEF_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= pair_rst;
      end else if (csr_wr_en) begin
         pair_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            coef[r][c] = pair_ff[2 * r + c / 2][COEF_W * (c % 2) +: COEF_W];
         end
      end
   end

   assign pt[0] = req_in_x;
   assign pt[1] = req_in_y;
   assign pt[2] = req_in_z;

   hptu_mac #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .ACC_WIDTH   (ACC_WIDTH)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .pt        (pt),
      .coef      (coef),
      .out_valid (mac_valid),
      .acc       (acc)
   );

   hptu_prep #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .ACC_WIDTH   (ACC_WIDTH)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (mac_valid),
      .acc      (acc),
      .ctl      (prep_ctl),
      .lane     (prep_lane),
      .fix      (prep_fix),
      .d2       (prep_d2),
      .rem      (prep_rem),
      .nlow     (prep_nlow)
   );

   // valid and fault ride alongside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < COORD_WIDTH; k++) begin
            ctl_dl_ff[k] <= '0;
         end
      end else if (en) begin
         ctl_dl_ff[0] <= prep_ctl;
         for (int k = 1; k < COORD_WIDTH; k++) begin
            ctl_dl_ff[k] <= ctl_dl_ff[k-1];
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_lane
      hptu_div #(
         .COORD_WIDTH (COORD_WIDTH),
         .ACC_WIDTH   (ACC_WIDTH)
      ) u_div (
         .clock     (clock),
         .en        (en),
         .ctl_in    (prep_lane[c]),
         .fix_in    (prep_fix[c]),
         .d2_in     (prep_d2),
         .rem_start (prep_rem[c]),
         .nlow_in   (prep_nlow[c]),
         .ctl_out   (div_lane[c]),
         .fix_out   (div_fix[c]),
         .q_out     (div_q[c])
      );
   end

   hptu_out #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ctl       (ctl_dl_ff[COORD_WIDTH-1]),
      .lane      (div_lane),
      .fix       (div_fix),
      .q         (div_q),
      .out_valid (rsp_valid),
      .val       (res),
      .saturated (rsp_saturated),
      .fault     (rsp_zero_w_fault)
   );

   assign rsp_out_x = res[0];
   assign rsp_out_y = res[1];
   assign rsp_out_z = res[2];

endmodule
